// ===== src/fbd_pkg.sv =====
// Package for the fractional baud divisor encoder.
// Holds the clock constants, the fraction code table and the stage payload types.
// No dependencies.
package fbd_pkg;

    // Field widths.
    localparam int BAUD_W  = 24;
    localparam int DVD_W   = 30;
    localparam int DIV_W   = 27;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 10;

    // Reference clocks times eight (divisor is kept in eighths).
    localparam logic [DVD_W-1:0] CLK_HIGH_X8 = 30'd960000000;
    localparam logic [DVD_W-1:0] CLK_LOW_X8  = 30'd384000000;

    // Above this rate high-speed mode uses the prescaler of ten.
    localparam logic [BAUD_W-1:0] HS_BAUD_LIMIT = 24'd732;

    // Rounding offsets: half the prescaler minus one.
    localparam logic [DVD_W-1:0] ROUND_P10 = 30'd4;
    localparam logic [DVD_W-1:0] ROUND_P16 = 30'd7;

    // Division by ten as a multiply by a reciprocal and a shift.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = DVD_W + 32;

    // Output word masks and flags.
    localparam logic [VALUE_W-1:0] CODE_VALUE_MASK = 16'hC000;
    localparam logic [VALUE_W-1:0] CODE_INDEX_MASK = 16'h0100;
    localparam logic [VALUE_W-1:0] INT_MASK        = 16'h3FFF;
    localparam logic [VALUE_W-1:0] PRESC10_FLAG    = 16'h0200;

    // Payload carried through the restoring divider stages.
    typedef struct packed {
        logic [BAUD_W-1:0] rem;
        logic [DVD_W-1:0]  dvd;
        logic [DVD_W-1:0]  quo;
        logic [BAUD_W-1:0] baud;
        logic              presc10;
        logic              zero;
    } t_div;

    // Control flags that travel beside the numeric payload after the divider.
    typedef struct packed {
        logic presc10;
        logic zero;
    } t_ctl;

    // Fraction code for the three low bits of the divisor.
    function automatic logic [VALUE_W-1:0] frac_code(input logic [2:0] frac);
        logic [VALUE_W-1:0] code;
        unique case (frac)
            3'd0:    code = 16'h0000;
            3'd1:    code = 16'hC000;
            3'd2:    code = 16'h8000;
            3'd3:    code = 16'h0100;
            3'd4:    code = 16'h4000;
            3'd5:    code = 16'h4100;
            3'd6:    code = 16'h8100;
            default: code = 16'hC100;
        endcase
        return code;
    endfunction

endpackage

// ===== src/fractional_baud_divisor_encoder.sv =====
// Pipeline: input register, 30 restoring divider stages of one quotient bit each,
// rounding add, prescaler division (reciprocal multiply or shift), output encode.
// Throughput: one request per cycle while the output is not stalled.
// Each stage stalls only when it is full and the next one is full, so bubbles close up.
// Reset (synchronous, active low) clears all valid bits and sets high-speed mode to 0.
// Depends on fbd_pkg, fbd_div_stage and fbd_post.
module fractional_baud_divisor_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fbd_pkg::BAUD_W-1:0]   i_baud_rate,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fbd_pkg::VALUE_W-1:0]  o_value_word,
    output logic [fbd_pkg::INDEX_W-1:0]  o_index_word,
    output logic                         o_zero_rate_error
);

    localparam int NSTG = fbd_pkg::DVD_W;

    logic           r_fast_clk_mode;
    logic           r_s0_valid;
    fbd_pkg::t_div  r_s0;
    fbd_pkg::t_div  n_s0;
    logic           s0_ready;

    logic           stg_valid [0:NSTG];
    logic           stg_ready [0:NSTG];
    fbd_pkg::t_div  stg_data  [0:NSTG];
    fbd_pkg::t_ctl  post_ctl;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_clk_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_fast_clk_mode <= i_cfg_wdata;
        end
    end

    // Input stage: pick the clock, the prescaler and flag a zero rate.
    always_comb begin
        n_s0.rem     = '0;
        n_s0.dvd     = r_fast_clk_mode ? fbd_pkg::CLK_HIGH_X8 : fbd_pkg::CLK_LOW_X8;
        n_s0.quo     = '0;
        n_s0.baud    = i_baud_rate;
        n_s0.presc10 = r_fast_clk_mode && (i_baud_rate > fbd_pkg::HS_BAUD_LIMIT);
        n_s0.zero    = (i_baud_rate == '0);
    end

    assign s0_ready = !r_s0_valid || stg_ready[0];
    assign o_ready  = s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s0_ready) begin
            r_s0 <= n_s0;
        end
    end

    assign stg_valid[0] = r_s0_valid;
    assign stg_data[0]  = r_s0;

    // Divider pipeline.
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        fbd_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

    // Rounding, prescaler division and encoding.
    assign post_ctl.presc10 = stg_data[NSTG].presc10;
    assign post_ctl.zero    = stg_data[NSTG].zero;

    fbd_post u_post (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (stg_valid[NSTG]),
        .o_ready           (stg_ready[NSTG]),
        .i_quo             (stg_data[NSTG].quo),
        .i_ctl             (post_ctl),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_value_word      (o_value_word),
        .o_index_word      (o_index_word),
        .o_zero_rate_error (o_zero_rate_error)
    );

endmodule

// ===== src/fbd_div_stage.sv =====
// One step of the pipelined restoring divider: one quotient bit per stage.
// Depends on fbd_pkg for the stage payload type.
module fbd_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fbd_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output fbd_pkg::t_div o_data
);

    logic                         r_valid;
    fbd_pkg::t_div                r_data;
    fbd_pkg::t_div                n_data;
    logic [fbd_pkg::BAUD_W:0]     trial;
    logic [fbd_pkg::BAUD_W:0]     diff;
    logic                         take;

    // The stage loads when it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        trial = {i_data.rem, i_data.dvd[fbd_pkg::DVD_W-1]};
        diff  = trial - {1'b0, i_data.baud};
        n_data     = i_data;
        n_data.dvd = {i_data.dvd[fbd_pkg::DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, i_data.baud}) begin
            n_data.rem = diff[fbd_pkg::BAUD_W-1:0];
            n_data.quo = {i_data.quo[fbd_pkg::DVD_W-2:0], 1'b1};
        end else begin
            n_data.rem = trial[fbd_pkg::BAUD_W-1:0];
            n_data.quo = {i_data.quo[fbd_pkg::DVD_W-2:0], 1'b0};
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/fbd_post.sv =====
// Back end: rounding add, division by the prescaler and word encoding.
// Three register stages; depends on fbd_pkg for constants, types and the code table.
module fbd_post (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fbd_pkg::DVD_W-1:0]    i_quo,
    input  fbd_pkg::t_ctl                i_ctl,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fbd_pkg::VALUE_W-1:0]  o_value_word,
    output logic [fbd_pkg::INDEX_W-1:0]  o_index_word,
    output logic                         o_zero_rate_error
);

    logic                          r_a_valid;
    logic [fbd_pkg::DVD_W-1:0]     r_a_sum;
    fbd_pkg::t_ctl                 r_a_ctl;
    logic                          a_ready;

    logic                          r_b_valid;
    logic [fbd_pkg::DIV_W-1:0]     r_b_div;
    fbd_pkg::t_ctl                 r_b_ctl;
    logic                          b_ready;

    logic                          r_c_valid;
    logic [fbd_pkg::VALUE_W-1:0]   r_c_value;
    logic [fbd_pkg::INDEX_W-1:0]   r_c_index;
    logic                          r_c_zero;
    logic                          c_ready;

    logic [fbd_pkg::DVD_W-1:0]     n_a_sum;
    logic [fbd_pkg::PROD_W-1:0]    prod;
    logic [fbd_pkg::DIV_W-1:0]     n_b_div;
    logic [fbd_pkg::VALUE_W-1:0]   code;
    logic [fbd_pkg::VALUE_W-1:0]   int_part;
    logic [fbd_pkg::VALUE_W-1:0]   idx_full;
    logic [fbd_pkg::VALUE_W-1:0]   n_c_value;
    logic [fbd_pkg::INDEX_W-1:0]   n_c_index;

    // Ready chain, from the output back.
    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Stage A: add half the prescaler minus one.
    assign n_a_sum = i_quo + (i_ctl.presc10 ? fbd_pkg::ROUND_P10 : fbd_pkg::ROUND_P16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            r_a_sum <= n_a_sum;
            r_a_ctl <= i_ctl;
        end
    end

    // Stage B: divide by ten through the reciprocal, or by sixteen by a shift.
    assign prod = {{(fbd_pkg::PROD_W-fbd_pkg::DVD_W){1'b0}}, r_a_sum}
                  * {{(fbd_pkg::PROD_W-32){1'b0}}, fbd_pkg::RECIP10};

    always_comb begin
        if (r_a_ctl.presc10) begin
            n_b_div = prod[fbd_pkg::RECIP_SHIFT +: fbd_pkg::DIV_W];
        end else begin
            n_b_div = {1'b0, r_a_sum[fbd_pkg::DVD_W-1:4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && b_ready) begin
            r_b_div <= n_b_div;
            r_b_ctl <= r_a_ctl;
        end
    end

    // Stage C: encode the integer part and the fraction code into the words, or zero both for a zero rate.
    always_comb begin
        code     = fbd_pkg::frac_code(r_b_div[2:0]);
        int_part = r_b_div[3 +: fbd_pkg::VALUE_W] & fbd_pkg::INT_MASK;
        idx_full = (code & fbd_pkg::CODE_INDEX_MASK)
                   | (r_b_ctl.presc10 ? fbd_pkg::PRESC10_FLAG : '0);
        if (r_b_ctl.zero) begin
            n_c_value = '0;
            n_c_index = '0;
        end else begin
            n_c_value = int_part | (code & fbd_pkg::CODE_VALUE_MASK);
            n_c_index = idx_full[fbd_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && c_ready) begin
            r_c_value <= n_c_value;
            r_c_index <= n_c_index;
            r_c_zero  <= r_b_ctl.zero;
        end
    end

    assign o_valid           = r_c_valid;
    assign o_value_word      = r_c_value;
    assign o_index_word      = r_c_index;
    assign o_zero_rate_error = r_c_zero;

endmodule
